@@ rtl/core/assert_macros.svh @@
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/tfn_pkg.sv @@
// Types and fixed widths shared by the triangle face normal pipeline.
package tfn_pkg;

    localparam int CW  = 16;        // vertex coordinate width
    localparam int EW  = CW + 1;    // edge width
    localparam int PW  = 2 * EW;    // product width
    localparam int MW  = PW;        // cross component magnitude width
    localparam int HW  = MW / 2;    // half of a magnitude, for split squaring
    localparam int SQW = 2 * MW;    // square width
    localparam int SW  = SQW + 2;   // sum of three squares
    localparam int RW  = SW / 2;    // square root width
    localparam int OW  = 16;        // normal component width

    typedef struct packed {
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] a_z;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] b_z;
        logic signed [CW-1:0] c_x;
        logic signed [CW-1:0] c_y;
        logic signed [CW-1:0] c_z;
    } tfn_in_t;

    typedef struct packed {
        logic signed [OW-1:0] normal_x;
        logic signed [OW-1:0] normal_y;
        logic signed [OW-1:0] normal_z;
        logic                 degenerate;
    } tfn_out_t;

endpackage

@@ rtl/core/tfn_front.sv @@
// Edges, cross product, component magnitudes and sum of squares (six stages).
module tfn_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  tfn_pkg::tfn_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0][tfn_pkg::MW-1:0] out_mag,
    output logic [2:0]                  out_neg,
    output logic                        out_zero,
    output logic [tfn_pkg::SW-1:0]      out_sum
);
    import tfn_pkg::*;

    localparam int NS = 6;
    localparam int NW = PW + 1;

    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;

    logic signed [EW-1:0] u_reg [3], u_next [3];
    logic signed [EW-1:0] w_reg [3], w_next [3];
    logic signed [PW-1:0] p_reg [6], p_next [6];
    logic signed [NW-1:0] n_val [3];

    logic [MW-1:0]  mag3_reg [3], mag3_next [3];
    logic [2:0]     neg3_reg, neg3_next;
    logic           zero3_reg, zero3_next;

    logic [MW-1:0]  hh_reg [3], hh_next [3];
    logic [MW-1:0]  hl_reg [3], hl_next [3];
    logic [MW-1:0]  ll_reg [3], ll_next [3];
    logic [MW-1:0]  mag4_reg [3];
    logic [2:0]     neg4_reg;
    logic           zero4_reg;

    logic [SQW-1:0] sq_reg [3], sq_next [3];
    logic [MW-1:0]  mag5_reg [3];
    logic [2:0]     neg5_reg;
    logic           zero5_reg;

    logic [SW-1:0]  sum_reg, sum_next;
    logic [MW-1:0]  mag6_reg [3];
    logic [2:0]     neg6_reg;
    logic           zero6_reg;

    // a stage takes new data when empty or when the next one moves
    always_comb begin
        rdy[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--) begin
            rdy[i] = ~v_reg[i] | rdy[i+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_comb begin
        u_next[0] = EW'(in_data.b_x) - EW'(in_data.a_x);
        u_next[1] = EW'(in_data.b_y) - EW'(in_data.a_y);
        u_next[2] = EW'(in_data.b_z) - EW'(in_data.a_z);
        w_next[0] = EW'(in_data.c_x) - EW'(in_data.b_x);
        w_next[1] = EW'(in_data.c_y) - EW'(in_data.b_y);
        w_next[2] = EW'(in_data.c_z) - EW'(in_data.b_z);

        p_next[0] = PW'(u_reg[1]) * PW'(w_reg[2]);
        p_next[1] = PW'(u_reg[2]) * PW'(w_reg[1]);
        p_next[2] = PW'(u_reg[2]) * PW'(w_reg[0]);
        p_next[3] = PW'(u_reg[0]) * PW'(w_reg[2]);
        p_next[4] = PW'(u_reg[0]) * PW'(w_reg[1]);
        p_next[5] = PW'(u_reg[1]) * PW'(w_reg[0]);

        for (int i = 0; i < 3; i++) begin
            n_val[i]     = NW'(p_reg[2*i]) - NW'(p_reg[2*i+1]);
            neg3_next[i] = n_val[i][NW-1];
            mag3_next[i] = n_val[i][NW-1] ? MW'(-n_val[i]) : MW'(n_val[i]);
        end
        zero3_next = (n_val[0] == '0) && (n_val[1] == '0) && (n_val[2] == '0);

        // square as hi^2, 2*hi*lo and lo^2 of the two halves
        for (int i = 0; i < 3; i++) begin
            hh_next[i] = MW'(mag3_reg[i][MW-1:HW]) * MW'(mag3_reg[i][MW-1:HW]);
            hl_next[i] = MW'(mag3_reg[i][MW-1:HW]) * MW'(mag3_reg[i][HW-1:0]);
            ll_next[i] = MW'(mag3_reg[i][HW-1:0]) * MW'(mag3_reg[i][HW-1:0]);
            sq_next[i] = {hh_reg[i], ll_reg[i]} + (SQW'(hl_reg[i]) << (HW + 1));
        end

        sum_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            u_reg <= u_next;
            w_reg <= w_next;
        end
        if (rdy[1]) begin
            p_reg <= p_next;
        end
        if (rdy[2]) begin
            mag3_reg  <= mag3_next;
            neg3_reg  <= neg3_next;
            zero3_reg <= zero3_next;
        end
        if (rdy[3]) begin
            hh_reg    <= hh_next;
            hl_reg    <= hl_next;
            ll_reg    <= ll_next;
            mag4_reg  <= mag3_reg;
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
        end
        if (rdy[4]) begin
            sq_reg    <= sq_next;
            mag5_reg  <= mag4_reg;
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
        end
        if (rdy[5]) begin
            sum_reg   <= sum_next;
            mag6_reg  <= mag5_reg;
            neg6_reg  <= neg5_reg;
            zero6_reg <= zero5_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            out_mag[i] = mag6_reg[i];
        end
    end

    assign out_neg  = neg6_reg;
    assign out_zero = zero6_reg;
    assign out_sum  = sum_reg;

endmodule

@@ rtl/core/tfn_isqrt.sv @@
// Pipelined floor square root, one root bit per stage.
module tfn_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tfn_pkg::SW-1:0]      in_sum,
    input  logic [2:0][tfn_pkg::MW-1:0] in_mag,
    input  logic [2:0]                  in_neg,
    input  logic                        in_zero,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tfn_pkg::RW-1:0]      out_root,
    output logic [2:0][tfn_pkg::MW-1:0] out_mag,
    output logic [2:0]                  out_neg,
    output logic                        out_zero
);
    import tfn_pkg::*;

    localparam int NS = RW;
    localparam int PV = 3 * MW + 4;

    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;

    logic [RW+1:0] rem_reg  [NS], rem_next  [NS];
    logic [RW-1:0] root_reg [NS], root_next [NS];
    logic [SW-1:0] x_reg    [NS], x_next    [NS];
    logic [PV-1:0] pass_reg [NS], pass_next [NS];
    logic [PV-1:0] in_pass;

    assign in_pass = {in_mag, in_neg, in_zero};

    always_comb begin
        rdy[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--) begin
            rdy[i] = ~v_reg[i] | rdy[i+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // each stage brings down the next two radicand bits and tries root bit one
    always_comb begin
        logic [RW+1:0] prem;
        logic [RW+1:0] cur;
        logic [RW+1:0] trial;
        logic [RW-1:0] proot;
        logic [SW-1:0] px;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                prem         = '0;
                proot        = '0;
                px           = in_sum;
                pass_next[k] = in_pass;
            end else begin
                prem         = rem_reg[k-1];
                proot        = root_reg[k-1];
                px           = x_reg[k-1];
                pass_next[k] = pass_reg[k-1];
            end
            cur   = {prem[RW-1:0], px[SW-1 -: 2]};
            trial = {proot, 2'b01};
            if (cur >= trial) begin
                rem_next[k]  = cur - trial;
                root_next[k] = {proot[RW-2:0], 1'b1};
            end else begin
                rem_next[k]  = cur;
                root_next[k] = {proot[RW-2:0], 1'b0};
            end
            x_next[k] = px << 2;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NS; k++) begin
            if (rdy[k]) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                x_reg[k]    <= x_next[k];
                pass_reg[k] <= pass_next[k];
            end
        end
    end

    assign out_root = root_reg[NS-1];
    assign {out_mag, out_neg, out_zero} = pass_reg[NS-1];

endmodule

@@ rtl/core/tfn_div.sv @@
// Pipelined scaled division of three magnitudes by the root, then sign and format.
module tfn_div #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tfn_pkg::RW-1:0]      in_root,
    input  logic [2:0][tfn_pkg::MW-1:0] in_mag,
    input  logic [2:0]                  in_neg,
    input  logic                        in_zero,
    output logic                        out_valid,
    input  logic                        out_ready,
    output tfn_pkg::tfn_out_t           out_data
);
    import tfn_pkg::*;

    localparam int QW = NORMAL_FRAC_BITS + 1;
    localparam int NS = QW + 1;
    localparam int VW = (QW + 1 > OW) ? QW + 1 : OW;

    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;

    logic [RW:0]   rem_reg  [QW][3], rem_next [QW][3];
    logic [QW-1:0] q_reg    [QW][3], q_next   [QW][3];
    logic [RW-1:0] m_reg    [QW], m_next [QW];
    logic [2:0]    neg_reg  [QW], neg_next [QW];
    logic          zero_reg [QW], zero_next [QW];
    logic [VW-1:0] sv [3];
    tfn_out_t      out_reg, out_next;

    always_comb begin
        rdy[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--) begin
            rdy[i] = ~v_reg[i] | rdy[i+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // first stage compares the magnitude itself, later ones the doubled remainder
    always_comb begin
        logic [RW:0]   cur;
        logic [QW-1:0] pq;
        logic [RW-1:0] pm;
        for (int j = 0; j < QW; j++) begin
            if (j == 0) begin
                m_next[j]    = in_root;
                neg_next[j]  = in_neg;
                zero_next[j] = in_zero;
            end else begin
                m_next[j]    = m_reg[j-1];
                neg_next[j]  = neg_reg[j-1];
                zero_next[j] = zero_reg[j-1];
            end
            pm = m_next[j];
            for (int l = 0; l < 3; l++) begin
                if (j == 0) begin
                    cur = (RW+1)'(in_mag[l]);
                    pq  = '0;
                end else begin
                    cur = {rem_reg[j-1][l][RW-1:0], 1'b0};
                    pq  = q_reg[j-1][l];
                end
                if (cur >= {1'b0, pm}) begin
                    rem_next[j][l] = cur - {1'b0, pm};
                    q_next[j][l]   = {pq[QW-2:0], 1'b1};
                end else begin
                    rem_next[j][l] = cur;
                    q_next[j][l]   = {pq[QW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            sv[l] = neg_reg[QW-1][l] ? VW'(0) - VW'(q_reg[QW-1][l]) : VW'(q_reg[QW-1][l]);
        end
        out_next.normal_x   = sv[0][OW-1:0];
        out_next.normal_y   = sv[1][OW-1:0];
        out_next.normal_z   = sv[2][OW-1:0];
        out_next.degenerate = zero_reg[QW-1];
        // zero cross product: drop the quotient
        if (zero_reg[QW-1]) begin
            out_next.normal_x = '0;
            out_next.normal_y = '0;
            out_next.normal_z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < QW; j++) begin
            if (rdy[j]) begin
                rem_reg[j]  <= rem_next[j];
                q_reg[j]    <= q_next[j];
                m_reg[j]    <= m_next[j];
                neg_reg[j]  <= neg_next[j];
                zero_reg[j] <= zero_next[j];
            end
        end
        if (rdy[NS-1]) begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

@@ rtl/core/triangle_face_normal.sv @@
// Triangle face unit normal. Takes three vertices A, B, C (signed Q7.8) per request
// and returns the unit normal of (B-A) x (C-B) in signed Q1.14, each component
// truncated toward zero, with degenerate set and a zero normal when the cross
// product vanishes. Fully pipelined: one request per cycle sustained while m_ready
// holds. The stages are the six front stages (edges, products, cross, split
// squares, squares, sum), one square-root bit per stage and one quotient bit
// per stage plus a format stage. Every stage carries a valid bit and stalls only
// when full and blocked, so a waiting result does not stop new requests while
// bubbles remain.
module triangle_face_normal #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tfn_pkg::tfn_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tfn_pkg::tfn_out_t m_data
);
    import tfn_pkg::*;

    logic                 f_valid, f_ready;
    logic [2:0][MW-1:0]   f_mag;
    logic [2:0]           f_neg;
    logic                 f_zero;
    logic [SW-1:0]        f_sum;

    logic                 r_valid, r_ready;
    logic [RW-1:0]        r_root;
    logic [2:0][MW-1:0]   r_mag;
    logic [2:0]           r_neg;
    logic                 r_zero;

    tfn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_mag   (f_mag),
        .out_neg   (f_neg),
        .out_zero  (f_zero),
        .out_sum   (f_sum)
    );

    tfn_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_sum    (f_sum),
        .in_mag    (f_mag),
        .in_neg    (f_neg),
        .in_zero   (f_zero),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_root  (r_root),
        .out_mag   (r_mag),
        .out_neg   (r_neg),
        .out_zero  (r_zero)
    );

    tfn_div #(
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .in_root   (r_root),
        .in_mag    (r_mag),
        .in_neg    (r_neg),
        .in_zero   (r_zero),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

@@ rtl/core/tfn_checker.sv @@
// Port-level checks for the triangle face normal block, bound to the top level.
`include "assert_macros.svh"

module tfn_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input tfn_pkg::tfn_out_t m_data
);

    `ASSERT_IMPLIES(a_degenerate_zero, aclk, aresetn, m_valid && m_data.degenerate,
        (m_data.normal_x == '0) && (m_data.normal_y == '0) && (m_data.normal_z == '0),
        "degenerate result with nonzero normal")

    `ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "stalled result dropped or changed")

    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid, "result valid right after reset")

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (.*);

@@ test/tfn_checker.sv @@
// Predicts the unit normal of each accepted triangle and checks the result stream.
module tfn_scoreboard (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  tfn_pkg::tfn_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  tfn_pkg::tfn_out_t m_data,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tfn_pkg::*;

    tfn_out_t normal_queue[$];

    function automatic tfn_out_t face_normal(tfn_in_t t);
        longint ux, uy, uz, vx, vy, vz;
        longint n[3];
        logic [63:0] mag_abs[3];
        logic [79:0] sum, probe;
        logic [39:0] root, trial;
        logic [63:0] q;
        tfn_out_t r;
        ux = longint'(t.b_x) - longint'(t.a_x);
        uy = longint'(t.b_y) - longint'(t.a_y);
        uz = longint'(t.b_z) - longint'(t.a_z);
        vx = longint'(t.c_x) - longint'(t.b_x);
        vy = longint'(t.c_y) - longint'(t.b_y);
        vz = longint'(t.c_z) - longint'(t.b_z);
        n[0] = uy * vz - uz * vy;
        n[1] = uz * vx - ux * vz;
        n[2] = ux * vy - uy * vx;
        r = '0;
        if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            mag_abs[i] = (n[i] < 0) ? 64'(-n[i]) : 64'(n[i]);
            sum += 80'(mag_abs[i]) * 80'(mag_abs[i]);
        end
        // floor square root, one bit at a time from the top
        root = '0;
        for (int k = 39; k >= 0; k--) begin
            trial = root | (40'd1 << k);
            probe = 80'(trial) * 80'(trial);
            if (probe <= sum) root = trial;
        end
        q = (mag_abs[0] << 14) / 64'(root);
        r.normal_x = (n[0] < 0) ? 16'(-q) : 16'(q);
        q = (mag_abs[1] << 14) / 64'(root);
        r.normal_y = (n[1] < 0) ? 16'(-q) : 16'(q);
        q = (mag_abs[2] << 14) / 64'(root);
        r.normal_z = (n[2] < 0) ? 16'(-q) : 16'(q);
        return r;
    endfunction

    assign pending = normal_queue.size();

    always @(posedge aclk) begin
        tfn_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                normal_queue = {normal_queue, face_normal(s_data)};
            if (m_valid && m_ready) begin
                if (normal_queue.size() == 0) begin
                    $error("unexpected result %p", m_data);
                    fail_count++;
                end else begin
                    want = normal_queue.pop_front();
                    if (m_data.normal_x !== want.normal_x) begin
                        $error("normal_x expected %0d got %0d", want.normal_x, m_data.normal_x);
                        fail_count++;
                    end
                    if (m_data.normal_y !== want.normal_y) begin
                        $error("normal_y expected %0d got %0d", want.normal_y, m_data.normal_y);
                        fail_count++;
                    end
                    if (m_data.normal_z !== want.normal_z) begin
                        $error("normal_z expected %0d got %0d", want.normal_z, m_data.normal_z);
                        fail_count++;
                    end
                    if (m_data.degenerate !== want.degenerate) begin
                        $error("degenerate expected %0b got %0b",
                               want.degenerate, m_data.degenerate);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

@@ test/tb_top.sv @@
// Top of the triangle face normal testbench: stimulus, flow control and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tfn_pkg::*;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    tfn_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    tfn_out_t m_data;
    int       fail_count;
    int       pending;
    int       send_idle_pct = 14;
    int       recv_idle_pct = 48;

    always #2 aclk = ~aclk;

    triangle_face_normal u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    tfn_scoreboard u_scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_triangle(tfn_in_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_data  <= t;
        s_valid <= 1'b1;
        // ready is stable between edges; accept at the next edge if high
        do begin
            @(negedge aclk);
            if (s_ready) break;
            @(posedge aclk);
        end while (1);
        @(posedge aclk);
    endtask

    function automatic tfn_in_t vertices(int ax, int ay, int az, int bx, int by, int bz,
                                         int cx, int cy, int cz);
        tfn_in_t t;
        t.a_x = 16'(ax); t.a_y = 16'(ay); t.a_z = 16'(az);
        t.b_x = 16'(bx); t.b_y = 16'(by); t.b_z = 16'(bz);
        t.c_x = 16'(cx); t.c_y = 16'(cy); t.c_z = 16'(cz);
        return t;
    endfunction

    function automatic int small_coord();
        return int'($urandom_range(64)) - 32;
    endfunction

    function automatic tfn_in_t random_triangle();
        tfn_in_t t;
        int k, dx, dy, dz;
        case ($urandom_range(9))
            0, 1, 2, 3: t = tfn_in_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
            4, 5: t = vertices(small_coord(), small_coord(), small_coord(),
                               small_coord(), small_coord(), small_coord(),
                               small_coord(), small_coord(), small_coord());
            6: begin
                // collinear: C continues the edge A->B
                t = vertices(small_coord(), small_coord(), small_coord(), 0, 0, 0, 0, 0, 0);
                dx = small_coord(); dy = small_coord(); dz = small_coord();
                k = int'($urandom_range(6)) - 3;
                t.b_x = t.a_x + 16'(dx); t.b_y = t.a_y + 16'(dy); t.b_z = t.a_z + 16'(dz);
                t.c_x = t.b_x + 16'(k * dx); t.c_y = t.b_y + 16'(k * dy);
                t.c_z = t.b_z + 16'(k * dz);
            end
            7: begin
                // repeated vertex
                t = tfn_in_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
                if ($urandom_range(1)) {t.b_x, t.b_y, t.b_z} = {t.a_x, t.a_y, t.a_z};
                else {t.c_x, t.c_y, t.c_z} = {t.b_x, t.b_y, t.b_z};
            end
            default: begin
                // triangle in a random axis-aligned plane
                t = tfn_in_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
                case ($urandom_range(2))
                    0: begin t.b_x = t.a_x; t.c_x = t.a_x; end
                    1: begin t.b_y = t.a_y; t.c_y = t.a_y; end
                    default: begin t.b_z = t.a_z; t.c_z = t.a_z; end
                endcase
            end
        endcase
        return t;
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        tfn_in_t directed[$];
        directed = {directed, vertices(0, 0, 0, 0, 0, 0, 0, 0, 0)};
        directed = {directed, vertices(256, 0, 0, 0, 256, 0, 0, 0, 256)};
        directed = {directed, vertices(0, 0, 0, 256, 0, 0, 256, 256, 0)};
        directed = {directed, vertices(0, 0, 0, 0, 256, 0, 0, 256, 256)};
        directed = {directed, vertices(0, 0, 0, 0, 0, 256, 256, 0, 256)};
        directed = {directed, vertices(0, 0, 0, 256, 0, 0, 256, -256, 0)};
        directed = {directed, vertices(-32768, -32768, -32768, 32767, -32768, -32768,
                                       32767, 32767, -32768)};
        directed = {directed, vertices(-32768, -32768, -32768, 32767, 32767, -32768,
                                       -32768, 32767, 32767)};
        directed = {directed, vertices(32767, -32768, 32767, -32768, 32767, -32768,
                                       32767, 32767, 32767)};
        directed = {directed, vertices(-32768, 32767, -32768, 32767, -32768, 32767,
                                       -32768, -32768, -32768)};
        directed = {directed, vertices(32767, 32767, 32767, 32767, 32767, 32767,
                                       32767, 32767, 32767)};
        directed = {directed, vertices(-32768, -32768, -32768, 32767, 32767, 32767,
                                       -32768, -32768, -32768)};
        directed = {directed, vertices(1, 2, 3, 2, 4, 6, 3, 6, 9)};
        directed = {directed, vertices(0, 0, 0, 1, 0, 0, 0, 1, 0)};
        directed = {directed, vertices(0, 0, 0, 1, 1, 1, 2, 2, 3)};
        directed = {directed, vertices(-1, -1, -1, 0, 0, 0, 32767, -32768, 1)};
        directed = {directed, vertices(5, 7, -3, 9, -2, 4, -6, 1, 8)};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_triangle(directed[i]);
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 48; recv_idle_pct = 14;
            end else if (phase == 2) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            for (int i = 0; i < 578; i++) begin
                send_triangle(random_triangle());
                // in the first phase, hold off once midway until the pipeline is empty
                if (phase == 0 && i == 300) wait_drained();
            end
            wait_drained();
        end

        repeat (80) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #2ms;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/tfn_pkg.sv
rtl/core/tfn_front.sv
rtl/core/tfn_isqrt.sv
rtl/core/tfn_div.sv
rtl/core/triangle_face_normal.sv
rtl/core/tfn_checker.sv
test/tfn_checker.sv
test/tb_top.sv
